// ===== src/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
`timescale 1ns / 1ps

package pba_pkg;

   // Result status codes
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StFull      = 3'd1;
   localparam logic [2:0] StBelow     = 3'd2;
   localparam logic [2:0] StUnaligned = 3'd3;
   localparam logic [2:0] StRange     = 3'd4;

   // Request opcodes
   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree  = 1'b1;

   // Bitmap word geometry
   localparam int WordBits   = 64;
   localparam int BitIdxBits = 6;

   typedef logic [WordBits-1:0]   word_type;
   typedef logic [BitIdxBits-1:0] bit_idx_type;

endpackage

// ===== src/page_bitmap_allocator.sv =====
// Top level: first-fit page allocator over a used-bit map held in RAM.
`timescale 1ns / 1ps

// Usage
// - Request channel: req_op / req_release_address are taken at a clock edge
//   with start high and busy low. op 0 allocates the lowest free page, op 1
//   frees the page at req_release_address.
// - Result channel: one beat per request on rsp_page_address / rsp_status,
//   valid for exactly one cycle while rsp_strobe is high. The receiver
//   cannot stall; every beat must be taken when shown.
// - Config: csr_wr_en / csr_wr_data write data_base; write only while idle.
// - Steps from accept to strobe: allocate does RAM read, modify and
//   write-back, then result; a full allocate or a free below data_base
//   goes straight to result. A free adds a check step first; a page size
//   not a power of two adds a reciprocal multiply and remainder step too.
//   A new request may be taken in the strobe cycle.
// - The bitmap lives in 64-bit RAM words; a per-word full bit picks the
//   word to search, and a per-word valid bit makes unwritten words read as
//   all free.
// - Reset: synchronous; clears valid and full bits, data_base and the FSM.
//   No clearing pass is needed, so requests are taken right after reset.

module page_bitmap_allocator #(
   parameter int PAGE_COUNT = 256,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_release_address,
   output logic        rsp_strobe,
   output logic [31:0] rsp_page_address,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int WordCount = (PAGE_COUNT + pba_pkg::WordBits - 1) / pba_pkg::WordBits;
   localparam int WordIdxW  = (WordCount > 1) ? $clog2(WordCount) : 1;
   localparam int LastBits  = PAGE_COUNT - (WordCount - 1) * pba_pkg::WordBits;
   localparam pba_pkg::word_type LastPad = (LastBits == pba_pkg::WordBits) ? '0 :
      ~((pba_pkg::word_type'(1) << LastBits) - pba_pkg::word_type'(1));
   localparam bit IsPow2    = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
   localparam int FloorLog2 = $clog2(PAGE_BYTES + 1) - 1;
   localparam int RecipShift = 31 + FloorLog2;
   localparam logic [31:0] Recip32 = 32'((64'd1 << RecipShift) / 64'(PAGE_BYTES));
   localparam logic [31:0] PageBytes32 = 32'(PAGE_BYTES);
   localparam logic [31:0] PageMask32  = 32'(PAGE_BYTES - 1);
   localparam logic [31:0] PageCount32 = 32'(PAGE_COUNT);
   localparam logic [WordIdxW-1:0] LastWord = WordIdxW'(WordCount - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EST,
      S_BACK,
      S_DIV,
      S_READ,
      S_MODIFY,
      S_FINISH
   } state_type;

   state_type             state_ff;
   logic                  op_ff;
   logic [2:0]            status_ff;
   logic [31:0]           base_ff;
   logic [WordIdxW-1:0]   word_ff;
   pba_pkg::bit_idx_type  bit_ff;
   logic [WordCount-1:0]  valid_ff;
   logic [WordCount-1:0]  full_ff;
   logic [31:0]           quo_ff;
   logic [31:0]           rem_ff;
   logic                  rsp_strobe_ff;
   logic [31:0]           rsp_page_address_ff;
   logic [2:0]            rsp_status_ff;

   logic                  ram_rd_en;
   logic                  ram_wr_en;
   pba_pkg::word_type     ram_rd_data;
   pba_pkg::word_type     cur_word;
   pba_pkg::word_type     pad_word;
   pba_pkg::word_type     new_word;
   pba_pkg::word_type     bit_mask;
   pba_pkg::bit_idx_type  zero_bit;
   pba_pkg::bit_idx_type  mod_bit;
   logic [WordIdxW-1:0]   free_word;
   logic                  any_free;
   logic [63:0]           est_prod;
   logic [31:0]           est_quo;
   logic [31:0]           est_back;
   logic                  rem_hi;
   logic [31:0]           rem_val;
   logic [31:0]           quo_val;
   logic [31:0]           alloc_offset;

   // Bitmap storage, one 64-page word per entry
   pba_ram #(
      .WIDTH(pba_pkg::WordBits),
      .DEPTH(WordCount)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(word_ff),
      .wr_data(new_word),
      .rd_en  (ram_rd_en),
      .rd_addr(word_ff),
      .rd_data(ram_rd_data)
   );

   assign ram_rd_en = (state_ff == S_READ);
   assign ram_wr_en = (state_ff == S_MODIFY);

   // First word that still has a free page
   always_comb begin
      free_word = '0;
      for (int w = WordCount - 1; w >= 0; w--) begin
         if (!full_ff[w]) begin
            free_word = WordIdxW'(w);
         end
      end
   end
   assign any_free = ~&full_ff;

   // Current word; never-written words read as all free
   assign cur_word = valid_ff[word_ff] ? ram_rd_data : '0;
   assign pad_word = (word_ff == LastWord) ? LastPad : '0;

   // Lowest clear bit of the word, pad bits count as used
   always_comb begin
      zero_bit = '0;
      for (int b = pba_pkg::WordBits - 1; b >= 0; b--) begin
         if (!(cur_word[b] | pad_word[b])) begin
            zero_bit = pba_pkg::BitIdxBits'(b);
         end
      end
   end

   // Set on allocate, clear on free
   assign mod_bit  = (op_ff == pba_pkg::OpAlloc) ? zero_bit : bit_ff;
   assign bit_mask = pba_pkg::word_type'(1) << mod_bit;
   assign new_word = (op_ff == pba_pkg::OpAlloc) ? (cur_word | bit_mask)
                                                 : (cur_word & ~bit_mask);

   // Quotient estimate by reciprocal multiply, low by at most one
   assign est_prod = 64'(quo_ff) * 64'(Recip32);
   assign est_quo  = 32'(est_prod >> RecipShift);
   assign est_back = quo_ff * PageBytes32;

   // Final quotient and remainder, one correction step
   assign rem_hi  = (rem_ff >= PageBytes32);
   assign rem_val = IsPow2 ? (quo_ff & PageMask32)
                           : (rem_hi ? (rem_ff - PageBytes32) : rem_ff);
   assign quo_val = IsPow2 ? (quo_ff >> $clog2(PAGE_BYTES))
                           : (quo_ff + {31'd0, rem_hi});

   // Byte offset of the allocated page, wraps modulo 2^32
   assign alloc_offset = 32'({word_ff, bit_ff}) * PageBytes32;

   // Control, bitmap summary and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         valid_ff      <= '0;
         full_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff     <= req_op;
                  status_ff <= pba_pkg::StOk;
                  if (req_op == pba_pkg::OpAlloc) begin
                     word_ff <= free_word;
                     if (any_free) begin
                        state_ff <= S_READ;
                     end else begin
                        status_ff <= pba_pkg::StFull;
                        state_ff  <= S_FINISH;
                     end
                  end else begin
                     quo_ff <= req_release_address - base_ff;
                     rem_ff <= req_release_address - base_ff;
                     if (req_release_address < base_ff) begin
                        status_ff <= pba_pkg::StBelow;
                        state_ff  <= S_FINISH;
                     end else begin
                        state_ff <= IsPow2 ? S_DIV : S_EST;
                     end
                  end
               end
            end
            S_EST: begin
               quo_ff   <= est_quo;
               state_ff <= S_BACK;
            end
            S_BACK: begin
               rem_ff   <= rem_ff - est_back;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (rem_val != '0) begin
                  status_ff <= pba_pkg::StUnaligned;
                  state_ff  <= S_FINISH;
               end else if (quo_val >= PageCount32) begin
                  status_ff <= pba_pkg::StRange;
                  state_ff  <= S_FINISH;
               end else begin
                  word_ff  <= quo_val[pba_pkg::BitIdxBits +: WordIdxW];
                  bit_ff   <= quo_val[pba_pkg::BitIdxBits-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               bit_ff            <= mod_bit;
               valid_ff[word_ff] <= 1'b1;
               full_ff[word_ff]  <= &(new_word | pad_word);
               state_ff          <= S_FINISH;
            end
            S_FINISH: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= status_ff;
               if (op_ff == pba_pkg::OpAlloc && status_ff == pba_pkg::StOk) begin
                  rsp_page_address_ff <= base_ff + alloc_offset;
               end else begin
                  rsp_page_address_ff <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== src/pba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
